// ----- rtl/eatrm_pkg.sv -----
package eatrm_pkg;

	localparam int Q = 30;
	localparam int VW = 34;
	localparam int ANGLE_WIDTH = 16;
	localparam int COEF_WIDTH = 16;
	localparam logic signed [VW-1:0] Q30_PI      = 34'sd3373259426;
	localparam logic signed [VW-1:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [VW-1:0] Q30_GAIN    = 34'sd652032874;
	localparam logic signed [VW-1:0] Q30_HALF    = 34'sd536870912;

	typedef enum logic [3:0] {
		SEQ_XZX = 4'd0, SEQ_XYX = 4'd1, SEQ_YXY = 4'd2, SEQ_YZY = 4'd3,
		SEQ_ZYZ = 4'd4, SEQ_ZXZ = 4'd5, SEQ_XZY = 4'd6, SEQ_XYZ = 4'd7,
		SEQ_YXZ = 4'd8, SEQ_YZX = 4'd9, SEQ_ZYX = 4'd10, SEQ_ZXY = 4'd11
	} seq_t;

	typedef struct packed {
		logic signed [ANGLE_WIDTH-1:0] angle_first;
		logic signed [ANGLE_WIDTH-1:0] angle_second;
		logic signed [ANGLE_WIDTH-1:0] angle_third;
		logic [3:0]                    axis_sequence;
	} in_item_t;

	typedef struct packed {
		logic signed [COEF_WIDTH-1:0] m00;
		logic signed [COEF_WIDTH-1:0] m01;
		logic signed [COEF_WIDTH-1:0] m02;
		logic signed [COEF_WIDTH-1:0] m10;
		logic signed [COEF_WIDTH-1:0] m11;
		logic signed [COEF_WIDTH-1:0] m12;
		logic signed [COEF_WIDTH-1:0] m20;
		logic signed [COEF_WIDTH-1:0] m21;
		logic signed [COEF_WIDTH-1:0] m22;
		logic                         bad_sequence;
	} out_item_t;

	function automatic logic signed [VW-1:0] atan_q30(input int i);
		logic signed [VW-1:0] r;
		begin
			case (i)
				0: r = 34'sd843314857;
				1: r = 34'sd497837829;
				2: r = 34'sd263043837;
				3: r = 34'sd133525159;
				4: r = 34'sd67021688;
				5: r = 34'sd33543516;
				6: r = 34'sd16775851;
				7: r = 34'sd8388437;
				8: r = 34'sd4194283;
				9: r = 34'sd2097149;
				default: r = (i < 31) ? (34'sd1 <<< (30 - i)) : 34'sd0;
			endcase
			return r;
		end
	endfunction

	// rounded Q30 product
	function automatic logic signed [VW-1:0] pm(input logic signed [VW-1:0] a,
			input logic signed [VW-1:0] b);
		logic signed [2*VW-1:0] p;
		begin
			p = a * b + 68'(Q30_HALF);
			return VW'(p >>> Q);
		end
	endfunction

endpackage

// ----- rtl/euler_angles_to_rotation_matrix.sv -----
// start runs in a valid shift register beside the CORDIC, then through stages A, B and C to done.
// Throughput: one item per cycle; busy stays low, the pipeline is fully streamed.
// Reset clears the valid bits only; the datapath holds no control state.
// The receiver cannot stall: each result shows on result for one cycle with done.
// Depth is set by the unrolled CORDIC, one micro-rotation per stage.
module euler_angles_to_rotation_matrix #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  eatrm_pkg::in_item_t  item,
	output logic                 done,
	output eatrm_pkg::out_item_t result
);
	localparam int VW = eatrm_pkg::VW;
	localparam int LAT = CORDIC_STAGES + 1;
	localparam int SH = 32 - eatrm_pkg::COEF_WIDTH;
	typedef logic signed [VW-1:0] v_t;

	v_t c0, s0, c1, s1, c2, s2;
	logic [LAT-1:0] vld_q;
	logic [3:0] seq_q[LAT];

	assign busy = 1'b0;

	eatrm_cordic #(.ANGLE_WIDTH(eatrm_pkg::ANGLE_WIDTH), .STAGES(CORDIC_STAGES)) u_c0 (
		.clk, .angle(item.angle_first), .cos_v(c0), .sin_v(s0));
	eatrm_cordic #(.ANGLE_WIDTH(eatrm_pkg::ANGLE_WIDTH), .STAGES(CORDIC_STAGES)) u_c1 (
		.clk, .angle(item.angle_second), .cos_v(c1), .sin_v(s1));
	eatrm_cordic #(.ANGLE_WIDTH(eatrm_pkg::ANGLE_WIDTH), .STAGES(CORDIC_STAGES)) u_c2 (
		.clk, .angle(item.angle_third), .cos_v(c2), .sin_v(s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		seq_q[0] <= item.axis_sequence;
		for (int i = 1; i < LAT; i++) seq_q[i] <= seq_q[i-1];
	end

	// stage A: pair products and first factors of the triples
	v_t c0c1_s1, c0c2_s1, c0s1_s1, c0s2_s1, c1c2_s1, c1s0_s1, c1s2_s1, c2s0_s1;
	v_t s0s1_s1, s0s2_s1, s1s2_s1, c2s1_s1;
	v_t c0k_s1, c1k_s1, c2k_s1, s0k_s1, s1k_s1, s2k_s1;
	logic [3:0] seq_s1;
	logic vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= vld_q[LAT-1];
	end

	always_ff @(posedge clk) begin
		c0c1_s1 <= eatrm_pkg::pm(c0, c1);
		c0c2_s1 <= eatrm_pkg::pm(c0, c2);
		c0s1_s1 <= eatrm_pkg::pm(c0, s1);
		c0s2_s1 <= eatrm_pkg::pm(c0, s2);
		c1c2_s1 <= eatrm_pkg::pm(c1, c2);
		c1s0_s1 <= eatrm_pkg::pm(c1, s0);
		c1s2_s1 <= eatrm_pkg::pm(c1, s2);
		c2s0_s1 <= eatrm_pkg::pm(c2, s0);
		s0s1_s1 <= eatrm_pkg::pm(s0, s1);
		s0s2_s1 <= eatrm_pkg::pm(s0, s2);
		s1s2_s1 <= eatrm_pkg::pm(s1, s2);
		c2s1_s1 <= eatrm_pkg::pm(c2, s1);
		c0k_s1 <= c0; c1k_s1 <= c1; c2k_s1 <= c2;
		s0k_s1 <= s0; s1k_s1 <= s1; s2k_s1 <= s2;
		seq_s1 <= seq_q[LAT-1];
	end

	// stage B: triple products T(a,b,c)=P(P(a,b),c)
	v_t t_c0c1c2, t_c1s0s2, t_c1c2s0, t_c0c1s2, t_c0c2s1, t_c0s1s2, t_c2s0s1, t_s0s1s2;
	v_t p_c0c1, p_c0c2, p_c0s1, p_c0s2, p_c1c2, p_c1s0, p_c1s2, p_c2s0;
	v_t p_s0s1, p_s0s2, p_s1s2, p_c2s1, k_c1, k_s1;
	logic [3:0] seq_s2;
	logic vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		t_c0c1c2 <= eatrm_pkg::pm(c0c1_s1, c2k_s1);
		t_c1s0s2 <= eatrm_pkg::pm(c1s0_s1, s2k_s1);
		t_c1c2s0 <= eatrm_pkg::pm(c1c2_s1, s0k_s1);
		t_c0c1s2 <= eatrm_pkg::pm(c0c1_s1, s2k_s1);
		t_c0c2s1 <= eatrm_pkg::pm(c0c2_s1, s1k_s1);
		t_c0s1s2 <= eatrm_pkg::pm(c0s1_s1, s2k_s1);
		t_c2s0s1 <= eatrm_pkg::pm(c2s0_s1, s1k_s1);
		t_s0s1s2 <= eatrm_pkg::pm(s0s1_s1, s2k_s1);
		p_c0c1 <= c0c1_s1; p_c0c2 <= c0c2_s1; p_c0s1 <= c0s1_s1; p_c0s2 <= c0s2_s1;
		p_c1c2 <= c1c2_s1; p_c1s0 <= c1s0_s1; p_c1s2 <= c1s2_s1; p_c2s0 <= c2s0_s1;
		p_s0s1 <= s0s1_s1; p_s0s2 <= s0s2_s1; p_s1s2 <= s1s2_s1; p_c2s1 <= c2s1_s1;
		k_c1 <= c1k_s1; k_s1 <= s1k_s1;
		seq_s2 <= seq_s1;
	end

	// stage C: pick formula, round and saturate
	v_t e[9];
	logic bad;

	always_comb begin
		for (int k = 0; k < 9; k++) e[k] = '0;
		bad = 1'b0;
		case (seq_s2)
			eatrm_pkg::SEQ_XZX: begin
				e[0] = k_c1; e[1] = -p_c2s1; e[2] = p_s1s2;
				e[3] = p_c0s1; e[4] = t_c0c1c2 - p_s0s2; e[5] = -p_c2s0 - t_c0c1s2;
				e[6] = p_s0s1; e[7] = p_c0s2 + t_c1c2s0; e[8] = p_c0c2 - t_c1s0s2;
			end
			eatrm_pkg::SEQ_XYX: begin
				e[0] = k_c1; e[1] = p_s1s2; e[2] = p_c2s1;
				e[3] = p_s0s1; e[4] = p_c0c2 - t_c1s0s2; e[5] = -p_c0s2 - t_c1c2s0;
				e[6] = -p_c0s1; e[7] = p_c2s0 + t_c0c1s2; e[8] = t_c0c1c2 - p_s0s2;
			end
			eatrm_pkg::SEQ_YXY: begin
				e[0] = p_c0c2 - t_c1s0s2; e[1] = p_s0s1; e[2] = p_c0s2 + t_c1c2s0;
				e[3] = p_s1s2; e[4] = k_c1; e[5] = -p_c2s1;
				e[6] = -p_c2s0 - t_c0c1s2; e[7] = p_c0s1; e[8] = t_c0c1c2 - p_s0s2;
			end
			eatrm_pkg::SEQ_YZY: begin
				e[0] = t_c0c1c2 - p_s0s2; e[1] = -p_c0s1; e[2] = p_c2s0 + t_c0c1s2;
				e[3] = p_c2s1; e[4] = k_c1; e[5] = p_s1s2;
				e[6] = -p_c0s2 - t_c1c2s0; e[7] = p_s0s1; e[8] = p_c0c2 - t_c1s0s2;
			end
			eatrm_pkg::SEQ_ZYZ: begin
				e[0] = t_c0c1c2 - p_s0s2; e[1] = -p_c2s0 - t_c0c1s2; e[2] = p_c0s1;
				e[3] = p_c0s2 + t_c1c2s0; e[4] = p_c0c2 - t_c1s0s2; e[5] = p_s0s1;
				e[6] = -p_c2s1; e[7] = p_s1s2; e[8] = k_c1;
			end
			eatrm_pkg::SEQ_ZXZ: begin
				e[0] = p_c0c2 - t_c1s0s2; e[1] = -p_c0s2 - t_c1c2s0; e[2] = p_s0s1;
				e[3] = p_c2s0 + t_c0c1s2; e[4] = t_c0c1c2 - p_s0s2; e[5] = -p_c0s1;
				e[6] = p_s1s2; e[7] = p_c2s1; e[8] = k_c1;
			end
			eatrm_pkg::SEQ_XZY: begin
				e[0] = p_c1c2; e[1] = -k_s1; e[2] = p_c1s2;
				e[3] = p_s0s2 + t_c0c2s1; e[4] = p_c0c1; e[5] = t_c0s1s2 - p_c2s0;
				e[6] = t_c2s0s1 - p_c0s2; e[7] = p_c1s0; e[8] = p_c0c2 + t_s0s1s2;
			end
			eatrm_pkg::SEQ_XYZ: begin
				e[0] = p_c1c2; e[1] = -p_c1s2; e[2] = k_s1;
				e[3] = p_c0s2 + t_c2s0s1; e[4] = p_c0c2 - t_s0s1s2; e[5] = -p_c1s0;
				e[6] = p_s0s2 - t_c0c2s1; e[7] = p_c2s0 + t_c0s1s2; e[8] = p_c0c1;
			end
			eatrm_pkg::SEQ_YXZ: begin
				e[0] = p_c0c2 + t_s0s1s2; e[1] = t_c2s0s1 - p_c0s2; e[2] = p_c1s0;
				e[3] = p_c1s2; e[4] = p_c1c2; e[5] = -k_s1;
				e[6] = t_c0s1s2 - p_c2s0; e[7] = t_c0c2s1 + p_s0s2; e[8] = p_c0c1;
			end
			eatrm_pkg::SEQ_YZX: begin
				e[0] = p_c0c1; e[1] = p_s0s2 - t_c0c2s1; e[2] = p_c2s0 + t_c0s1s2;
				e[3] = k_s1; e[4] = p_c1c2; e[5] = -p_c1s2;
				e[6] = -p_c1s0; e[7] = p_c0s2 + t_c2s0s1; e[8] = p_c0c2 - t_s0s1s2;
			end
			eatrm_pkg::SEQ_ZYX: begin
				e[0] = p_c0c1; e[1] = t_c0s1s2 - p_c2s0; e[2] = p_s0s2 + t_c0c2s1;
				e[3] = p_c1s0; e[4] = p_c0c2 + t_s0s1s2; e[5] = t_c2s0s1 - p_c0s2;
				e[6] = -k_s1; e[7] = p_c1s2; e[8] = p_c1c2;
			end
			eatrm_pkg::SEQ_ZXY: begin
				e[0] = p_c0c2 - t_s0s1s2; e[1] = -p_c1s0; e[2] = p_c0s2 + t_c2s0s1;
				e[3] = p_c2s0 + t_c0s1s2; e[4] = p_c0c1; e[5] = p_s0s2 - t_c0c2s1;
				e[6] = -p_c1s2; e[7] = k_s1; e[8] = p_c1c2;
			end
			default: bad = 1'b1;
		endcase
	end

	function automatic logic [eatrm_pkg::COEF_WIDTH-1:0] to_coef(input v_t v);
		v_t r;
		v_t lim;
		begin
			lim = v_t'(1) <<< (eatrm_pkg::COEF_WIDTH - 2);
			if (SH > 0) r = (v + (v_t'(1) <<< (SH - 1))) >>> SH;
			else r = v;
			if (r > lim) r = lim;
			if (r < -lim) r = -lim;
			return r[eatrm_pkg::COEF_WIDTH-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_s2;
	end

	always_ff @(posedge clk) begin
		result.m00 <= to_coef(e[0]);
		result.m01 <= to_coef(e[1]);
		result.m02 <= to_coef(e[2]);
		result.m10 <= to_coef(e[3]);
		result.m11 <= to_coef(e[4]);
		result.m12 <= to_coef(e[5]);
		result.m20 <= to_coef(e[6]);
		result.m21 <= to_coef(e[7]);
		result.m22 <= to_coef(e[8]);
		result.bad_sequence <= bad;
	end

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |=> done) else $error("done lost");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s2 |=> !done) else $error("spurious done");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.bad_sequence |-> result.m00 == '0 && result.m22 == '0)
		else $error("bad sequence gave nonzero matrix");
endmodule

// ----- rtl/eatrm_cordic.sv -----
module eatrm_cordic #(
	parameter int ANGLE_WIDTH = 16,
	parameter int STAGES = 16
) (
	input  logic                          clk,
	input  logic signed [ANGLE_WIDTH-1:0] angle,
	output logic signed [eatrm_pkg::VW-1:0] cos_v,
	output logic signed [eatrm_pkg::VW-1:0] sin_v
);
	localparam int VW = eatrm_pkg::VW;

	logic signed [VW-1:0] x_s[STAGES+1];
	logic signed [VW-1:0] y_s[STAGES+1];
	logic signed [VW-1:0] z_s[STAGES+1];
	logic                 f_s[STAGES+1];
	logic signed [VW-1:0] z0;

	assign z0 = VW'(angle) <<< (33 - ANGLE_WIDTH);

	// range fold, one register stage
	always_ff @(posedge clk) begin
		x_s[0] <= eatrm_pkg::Q30_GAIN;
		y_s[0] <= '0;
		if (z0 > eatrm_pkg::Q30_HALF_PI) begin
			z_s[0] <= z0 - eatrm_pkg::Q30_PI;
			f_s[0] <= 1'b1;
		end else if (z0 < -eatrm_pkg::Q30_HALF_PI) begin
			z_s[0] <= z0 + eatrm_pkg::Q30_PI;
			f_s[0] <= 1'b1;
		end else begin
			z_s[0] <= z0;
			f_s[0] <= 1'b0;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_st
		always_ff @(posedge clk) begin
			f_s[i+1] <= f_s[i];
			if (!z_s[i][VW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - eatrm_pkg::atan_q30(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + eatrm_pkg::atan_q30(i);
			end
		end
	end

	assign cos_v = f_s[STAGES] ? -x_s[STAGES] : x_s[STAGES];
	assign sin_v = f_s[STAGES] ? -y_s[STAGES] : y_s[STAGES];
endmodule
